// File: hw/rtl/hsl2rgb_pkg.sv
`default_nettype none

package hsl2rgb_pkg;

    localparam int HUE_BITS      = 9;
    localparam int FRAC_BITS_DEF = 8;
    localparam int CH_W          = 8;
    localparam int K2_W          = 6;

    // 360 degrees and above is gray
    localparam logic [HUE_BITS-1:0] HUE_GRAY = HUE_BITS'(360);

    // per-channel chroma weight, half of the C / X / 0 coefficient
    localparam logic signed [K2_W-1:0] K2_CHROMA = K2_W'(30);
    localparam logic signed [K2_W-1:0] K2_ZERO   = -K2_W'(30);

    typedef enum logic [2:0] {
        SECT_RG = 3'd0,   // 0..59: R=C G=X
        SECT_GR = 3'd1,   // 60..119: R=X G=C
        SECT_GB = 3'd2,   // 120..179: G=C B=X
        SECT_BG = 3'd3,   // 180..239: G=X B=C
        SECT_BR = 3'd4,   // 240..299: R=X B=C
        SECT_RB = 3'd5,   // 300..359: R=C B=X
        SECT_GRAY = 3'd6
    } hue_sect_t;

endpackage

`default_nettype wire

// File: hw/rtl/hsl2rgb_chan.sv
`default_nettype none

// One color channel: weight chroma, add lightness term, scale by 255/(60*one^2), clamp.
// Three register stages; all advance together on adv.
module hsl2rgb_chan
    import hsl2rgb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire                         aclk,
    input  wire                         adv,
    input  wire signed [2*FRAC_BITS+4:0] cn,
    input  wire        [2*FRAC_BITS+6:0] base,
    input  wire signed [K2_W-1:0]       k2,
    output logic       [CH_W-1:0]       chan_out
);

    localparam int CNW = 2*FRAC_BITS + 5;
    localparam int BW  = 2*FRAC_BITS + 7;
    localparam int PW  = CNW + K2_W;
    localparam int SW  = PW + 1;
    localparam int TW  = SW + 5;
    localparam int SH  = 2*FRAC_BITS + 2;
    localparam int QW  = TW - SH;

    logic signed [PW-1:0] prod_reg, prod_next;
    logic [BW-1:0]        base_reg;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic [CH_W-1:0]      out_reg, out_next;
    logic signed [TW-1:0] sx, scaled;
    logic [QW-1:0]        q;

    assign prod_next = PW'(cn) * PW'(k2);
    assign sum_next  = {prod_reg[PW-1], prod_reg} + {{(SW-BW){1'b0}}, base_reg};

    // x*17 then divide by 4*one^2 is the 255/60 scale
    always_comb begin
        sx     = {{(TW-SW){sum_reg[SW-1]}}, sum_reg};
        scaled = (sx <<< 4) + sx;
        q      = scaled[TW-1:SH];
        if (sum_reg[SW-1]) begin
            out_next = '0;
        end else if (|q[QW-1:CH_W]) begin
            out_next = '1;
        end else begin
            out_next = q[CH_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
            base_reg <= base;
            sum_reg  <= sum_next;
            out_reg  <= out_next;
        end
    end

    assign chan_out = out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/hsl_to_rgb_converter.sv
// HSL to 8-bit RGB color converter.
//
// Input stream (s_): one HSL color per word, hue in degrees (360 and up gives
// gray), saturation and lightness with 2^FRAC_BITS meaning 1.0.
// Output stream (m_): one RGB word per input word, in order.
//
// Five-stage pipeline: hue decode and lightness distance, chroma multiply,
// per-channel chroma weighting, offset add, scale and clamp. m_tvalid comes
// from the valid bit of the last stage, which moves with its word through
// every stage register; one word is taken every cycle while the receiver
// keeps m_tready high.
//
// When the receiver stalls with a word waiting, every stage holds and s_tready
// drops in the same cycle; nothing is dropped or repeated. Bubbles are not
// squeezed out, so a stall costs one cycle of input for each stalled cycle.
//
// Reset (aresetn low, synchronous) clears all valid bits; data registers are
// not reset. The block has no state between words.
`default_nettype none

module hsl_to_rgb_converter
    import hsl2rgb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // hue_deg[8:0], sat_level, light_level (FRAC_BITS+1 each), zero pad to bytes
    input  wire  [((HUE_BITS+2*(FRAC_BITS+1)+7)/8)*8-1:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // red_out[7:0], green_out[15:8], blue_out[23:16]
    output logic [3*CH_W-1:0] m_tdata
);

    localparam int LW    = FRAC_BITS + 1;
    localparam int DW    = FRAC_BITS + 3;
    localparam int CNW   = 2*FRAC_BITS + 5;
    localparam int BW    = 2*FRAC_BITS + 7;
    localparam int NSTG  = 5;

    logic              adv;
    logic [NSTG-1:0]   vld_reg, vld_next;

    logic [HUE_BITS-1:0] hue;
    logic [LW-1:0]       sat, lit;
    hue_sect_t           sect;
    logic [HUE_BITS-1:0] hm;
    logic [5:0]          hd;
    logic signed [K2_W-1:0] k2x;
    logic signed [K2_W-1:0] k2_next [3];
    logic signed [DW-1:0]   dtmp, cw_next;
    logic [DW-2:0]          dabs;

    logic signed [DW-1:0]   cw_reg;
    logic [LW-1:0]          sat_reg, lit_reg;
    logic signed [K2_W-1:0] k2_reg [3];

    logic signed [CNW-1:0]  cn_reg, cn_next;
    logic [BW-1:0]          base_reg, base_next;
    logic signed [K2_W-1:0] k2b_reg [3];

    logic [CH_W-1:0]        chan [3];

    assign adv      = !vld_reg[NSTG-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = {chan[2], chan[1], chan[0]};

    assign vld_next = {vld_reg[NSTG-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    assign hue = s_tdata[HUE_BITS-1:0];
    assign sat = s_tdata[HUE_BITS+LW-1:HUE_BITS];
    assign lit = s_tdata[HUE_BITS+2*LW-1:HUE_BITS+LW];

    // stage 1: sector, position within the 120-degree pair, |2L - 1|
    always_comb begin
        if (hue < HUE_BITS'(60)) begin
            sect = SECT_RG;
        end else if (hue < HUE_BITS'(120)) begin
            sect = SECT_GR;
        end else if (hue < HUE_BITS'(180)) begin
            sect = SECT_GB;
        end else if (hue < HUE_BITS'(240)) begin
            sect = SECT_BG;
        end else if (hue < HUE_BITS'(300)) begin
            sect = SECT_BR;
        end else if (hue < HUE_GRAY) begin
            sect = SECT_RB;
        end else begin
            sect = SECT_GRAY;
        end

        if (hue < HUE_BITS'(120)) begin
            hm = hue;
        end else if (hue < HUE_BITS'(240)) begin
            hm = hue - HUE_BITS'(120);
        end else begin
            hm = hue - HUE_BITS'(240);
        end
        hd  = (hm >= HUE_BITS'(60)) ? 6'(hm - HUE_BITS'(60)) : 6'(HUE_BITS'(60) - hm);
        k2x = K2_CHROMA - K2_W'(hd);

        case (sect)
            SECT_RG: begin
                k2_next[0] = K2_CHROMA; k2_next[1] = k2x;       k2_next[2] = K2_ZERO;
            end
            SECT_GR: begin
                k2_next[0] = k2x;       k2_next[1] = K2_CHROMA; k2_next[2] = K2_ZERO;
            end
            SECT_GB: begin
                k2_next[0] = K2_ZERO;   k2_next[1] = K2_CHROMA; k2_next[2] = k2x;
            end
            SECT_BG: begin
                k2_next[0] = K2_ZERO;   k2_next[1] = k2x;       k2_next[2] = K2_CHROMA;
            end
            SECT_BR: begin
                k2_next[0] = k2x;       k2_next[1] = K2_ZERO;   k2_next[2] = K2_CHROMA;
            end
            SECT_RB: begin
                k2_next[0] = K2_CHROMA; k2_next[1] = K2_ZERO;   k2_next[2] = k2x;
            end
            default: begin
                k2_next[0] = K2_ZERO;   k2_next[1] = K2_ZERO;   k2_next[2] = K2_ZERO;
            end
        endcase

        dtmp    = {1'b0, lit, 1'b0} - DW'(1 << FRAC_BITS);
        dabs    = dtmp[DW-1] ? (DW-1)'(-dtmp) : dtmp[DW-2:0];
        cw_next = DW'(1 << FRAC_BITS) - {1'b0, dabs};
    end

    // stage 2: chroma, and the lightness term 60 * L * one
    assign cn_next   = CNW'(cw_reg) * CNW'($signed({1'b0, sat_reg}));
    assign base_next = {(BW-FRAC_BITS)'(lit_reg) * (BW-FRAC_BITS)'(60), {FRAC_BITS{1'b0}}};

    always_ff @(posedge aclk) begin
        if (adv) begin
            cw_reg   <= cw_next;
            sat_reg  <= sat;
            lit_reg  <= lit;
            k2_reg   <= k2_next;
            cn_reg   <= cn_next;
            base_reg <= base_next;
            k2b_reg  <= k2_reg;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_chan
        hsl2rgb_chan #(
            .FRAC_BITS(FRAC_BITS)
        ) u_chan (
            .aclk    (aclk),
            .adv     (adv),
            .cn      (cn_reg),
            .base    (base_reg),
            .k2      (k2b_reg[i]),
            .chan_out(chan[i])
        );
    end

endmodule

`default_nettype wire

// File: hw/rtl/hsl2rgb_checker.sv
`default_nettype none

module hsl2rgb_checker
    import hsl2rgb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input wire                aclk,
    input wire                aresetn,
    input wire                s_tvalid,
    input wire                s_tready,
    input wire                m_tvalid,
    input wire                m_tready,
    input wire [3*CH_W-1:0]   m_tdata
);

    // input side is free whenever the output word is absent or being taken
    a_ready_follows_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not track output stall");

    // nothing comes out in the cycle after a reset edge
    a_no_early_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high right after reset");

    // a word accepted while the receiver keeps m_tready high reaches the output
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && m_tready) ##1 m_tready ##1 m_tready ##1 m_tready
        ##1 m_tready |=> m_tvalid)
        else $error("word lost in pipeline");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output word changed");

endmodule

bind hsl_to_rgb_converter hsl2rgb_checker #(
    .FRAC_BITS(FRAC_BITS)
) u_hsl2rgb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

`default_nettype wire

// File: test/tb_hsl_to_rgb_converter.sv
`timescale 1ns / 100ps

module tb_hsl_to_rgb_converter;
    import hsl2rgb_pkg::*;

    localparam int LVL_W  = FRAC_BITS_DEF + 1;
    localparam int S_W    = ((HUE_BITS + 2 * LVL_W + 7) / 8) * 8;
    localparam int M_W    = 3 * CH_W;
    localparam int MAX_PRINTS = 200;

    // same layout as m_tdata: red lowest
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgb_t;

    class rgb_scoreboard;
        rgb_t expected_rgb_q[$];
        int   errors = 0;

        function logic [CH_W-1:0] scale_channel(longint part, longint base, longint den);
            longint num;
            longint q;
            num = (part + base) * 255;
            if (num <= 0)
                return '0;
            q = num / den;
            if (q > 255)
                q = 255;
            return CH_W'(q);
        endfunction

        // exact over a common denominator of 120 * 2^(2*FRAC_BITS)
        function rgb_t convert_hsl(logic [HUE_BITS-1:0] hue, logic [LVL_W-1:0] sat,
                                   logic [LVL_W-1:0] lit);
            longint one, den, hue_v, sat_v, lit_v, lit_dist, chroma;
            longint c_term, x_term, base, w, r, g, b;
            hue_sect_t sect;
            rgb_t rgb;
            hue_v = hue;
            sat_v = sat;
            lit_v = lit;
            one = longint'(1) << FRAC_BITS_DEF;
            den = 120 * one * one;
            lit_dist = 2 * lit_v - one;
            if (lit_dist < 0)
                lit_dist = -lit_dist;
            chroma = (one - lit_dist) * sat_v;
            c_term = 120 * chroma;
            w = (hue_v % 120) - 60;
            if (w < 0)
                w = -w;
            w = 60 - w;
            x_term = 2 * chroma * w;
            base = 120 * lit_v * one - 60 * chroma;
            sect = (hue_v >= 360) ? SECT_GRAY : hue_sect_t'(3'(hue_v / 60));
            r = 0;
            g = 0;
            b = 0;
            case (sect)
                SECT_RG: begin r = c_term; g = x_term; end
                SECT_GR: begin r = x_term; g = c_term; end
                SECT_GB: begin g = c_term; b = x_term; end
                SECT_BG: begin g = x_term; b = c_term; end
                SECT_BR: begin r = x_term; b = c_term; end
                SECT_RB: begin r = c_term; b = x_term; end
                default: ;
            endcase
            rgb.red   = scale_channel(r, base, den);
            rgb.green = scale_channel(g, base, den);
            rgb.blue  = scale_channel(b, base, den);
            return rgb;
        endfunction

        function void note_hsl(logic [S_W-1:0] word);
            expected_rgb_q.push_back(convert_hsl(word[HUE_BITS-1:0],
                                                 word[HUE_BITS +: LVL_W],
                                                 word[HUE_BITS+LVL_W +: LVL_W]));
        endfunction

        function void check_rgb(logic [M_W-1:0] word);
            rgb_t got;
            rgb_t exp_rgb;
            got = word;
            if (expected_rgb_q.size() == 0) begin
                errors++;
                if (errors <= MAX_PRINTS)
                    $display("%0t: unexpected rgb word r=%0d g=%0d b=%0d",
                             $time, got.red, got.green, got.blue);
                return;
            end
            exp_rgb = expected_rgb_q.pop_front();
            if (got.red !== exp_rgb.red || got.green !== exp_rgb.green ||
                got.blue !== exp_rgb.blue) begin
                errors++;
                if (errors <= MAX_PRINTS)
                    $display("%0t: rgb mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                             $time, exp_rgb.red, exp_rgb.green, exp_rgb.blue,
                             got.red, got.green, got.blue);
            end
        endfunction

        function int pending();
            return expected_rgb_q.size();
        endfunction
    endclass

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    // hue_deg[8:0], sat_level[17:9], light_level[26:18], zero pad
    logic [S_W-1:0] s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    // red_out[7:0], green_out[15:8], blue_out[23:16]
    logic [M_W-1:0] m_tdata;

    int send_idle_pct = 36;
    int recv_idle_pct = 48;

    rgb_scoreboard sb = new;

    hsl_to_rgb_converter u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    always @(negedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_hsl(s_tdata);
        if (aresetn && m_tvalid && m_tready)
            sb.check_rgb(m_tdata);
    end

    // called and returns at a falling edge
    task automatic send_hsl(input logic [HUE_BITS-1:0] hue, input logic [LVL_W-1:0] sat,
                            input logic [LVL_W-1:0] lit);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'({lit, sat, hue});
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_random_hsl(input int count);
        int kind;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(99);
            if (kind < 70)
                send_hsl(HUE_BITS'($urandom_range(359)), LVL_W'($urandom_range(256)),
                         LVL_W'($urandom_range(256)));
            else if (kind < 80)
                send_hsl(HUE_BITS'($urandom_range(511, 360)), LVL_W'($urandom_range(256)),
                         LVL_W'($urandom_range(256)));
            else
                send_hsl(HUE_BITS'($urandom), LVL_W'($urandom), LVL_W'($urandom));
        end
    endtask

    initial begin
        #200000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // sector edges at full saturation, mid lightness
        send_hsl(0, 256, 128);
        send_hsl(59, 256, 128);
        send_hsl(60, 256, 128);
        send_hsl(119, 256, 128);
        send_hsl(120, 256, 128);
        send_hsl(179, 256, 128);
        send_hsl(180, 256, 128);
        send_hsl(239, 256, 128);
        send_hsl(240, 256, 128);
        send_hsl(299, 256, 128);
        send_hsl(300, 256, 128);
        send_hsl(359, 256, 128);
        // gray region
        send_hsl(360, 256, 128);
        send_hsl(511, 511, 200);
        // black, white, no saturation
        send_hsl(90, 256, 0);
        send_hsl(90, 256, 256);
        send_hsl(200, 0, 100);
        send_hsl(0, 0, 0);
        // saturation above one, channel driven negative
        send_hsl(30, 511, 10);
        send_hsl(250, 511, 128);
        // lightness above one: negative chroma and clamp high
        send_hsl(150, 511, 300);
        send_hsl(330, 256, 511);
        send_hsl(511, 511, 511);
        send_random_hsl(230);

        send_idle_pct = 48;
        recv_idle_pct = 36;
        send_random_hsl(235);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_hsl(235);

        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
